@@ sv/ffa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the first-fit free-list allocator.
// No dependencies; every other file imports this package.
package ffa_pkg;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 24;
    localparam int HEAP_W = 25;
    localparam int BRK_W  = 25;
    localparam int SUM_W  = 27;
    localparam int CFG_IDX_W = 1;

    localparam int FREE_ENTRIES_DEF    = 16;
    localparam int MIN_BLOCK_BYTES_DEF = 16;
    localparam int HEADER_BYTES_DEF    = 4;
    localparam int SENTINEL_BYTES_DEF  = 20;

    localparam logic [HEAP_W-1:0] HEAP_BYTES_RESET = HEAP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAP_BASE  = 1'b0,
        REG_HEAP_BYTES = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_SPACE   = 2'd1,
        STATUS_TABLE_FULL = 2'd2
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
        logic [SIZE_W-1:0] block_size;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        status_t           status;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic              fits;
        logic [ADDR_W-1:0] address;
    } carve_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MOVE,
        ST_CARVE,
        ST_DONE
    } state_t;

endpackage

@@ sv/first_fit_free_list_allocator.sv @@
`timescale 1ns / 1ps
// First-fit free-list allocator: each allocate or free request gets one result
// carrying a user address and a status. Freed blocks sit in a table of
// FREE_ENTRIES entries held in a single-port-read, single-port-write memory,
// most recently freed first; blocks are never merged. A free goes straight to
// ST_DONE, which loads the result and raises m_valid once the output register
// is free. An allocate walks the table one entry per cycle from the most recent
// free; on a hit every younger entry is moved down one place, one entry per
// cycle, then ST_DONE loads the result. A miss runs the search, then ST_CARVE
// carves a block at the break and ST_DONE loads the result; a zero-size request
// or an empty table skips the search. A new request is taken the cycle after
// the previous result is loaded, even if that result still waits on m_ready.
// The table needs no clearing after reset.
// Depends on ffa_pkg, ffa_table and ffa_break.
module first_fit_free_list_allocator #(
    parameter int FREE_ENTRIES    = ffa_pkg::FREE_ENTRIES_DEF,
    parameter int MIN_BLOCK_BYTES = ffa_pkg::MIN_BLOCK_BYTES_DEF,
    parameter int HEADER_BYTES    = ffa_pkg::HEADER_BYTES_DEF,
    parameter int SENTINEL_BYTES  = ffa_pkg::SENTINEL_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffa_pkg::ADDR_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ffa_pkg::req_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ffa_pkg::rsp_t                   m_data
);
    import ffa_pkg::*;

    localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] heap_base_reg;
    logic [HEAP_W-1:0] heap_bytes_reg;

    req_t              req_reg;
    rsp_t              rsp_reg, rsp_next;
    rsp_t              m_data_reg;
    logic              m_valid_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;

    logic              s_fire;
    logic              out_free;
    logic              count_full;
    logic [IDX_W-1:0]  count_last;
    logic              ptr_at_last;
    logic              ptr_at_zero;
    logic              hit;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_entry;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_entry;

    logic              carve_commit;
    carve_t            carve;

    ffa_table #(
        .DEPTH (FREE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    ffa_break #(
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .SENTINEL_BYTES  (SENTINEL_BYTES)
    ) u_break (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .heap_base    (heap_base_reg),
        .heap_bytes   (heap_bytes_reg),
        .request_size (req_reg.request_size),
        .commit       (carve_commit),
        .carve        (carve)
    );

    // Hold off transfers while reset is asserted
    assign s_ready     = (state_reg == ST_IDLE) && aresetn;
    assign s_fire      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign count_full  = (count_reg == CNT_W'(FREE_ENTRIES));
    assign count_last  = IDX_W'(count_reg - CNT_W'(1));
    assign ptr_at_last = (ptr_reg == count_last);
    assign ptr_at_zero = (ptr_reg == '0);
    assign hit         = (rd_entry.size >= req_reg.request_size);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= '0;
            heap_bytes_reg <= HEAP_BYTES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                REG_HEAP_BYTES: heap_bytes_reg <= cfg_data[HEAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.kind == KIND_FREE) begin
                        state_next = ST_DONE;
                    end else if (s_data.request_size == '0 || count_reg == '0) begin
                        state_next = ST_CARVE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (hit && ptr_at_last) begin
                    state_next = ST_DONE;
                end else if (hit) begin
                    state_next = ST_MOVE;
                end else if (ptr_at_zero) begin
                    state_next = ST_CARVE;
                end
            end
            ST_MOVE: begin
                if (ptr_at_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_CARVE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and table access; the table is stored oldest at index 0
    always_comb begin
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        rsp_next     = rsp_reg;
        rd_addr      = ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = ptr_reg - IDX_W'(1);
        wr_entry     = rd_entry;
        carve_commit = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = count_last;
                if (s_fire) begin
                    rsp_next.address = '0;
                    rsp_next.status  = STATUS_OK;
                    ptr_next         = count_last;
                    if (s_data.kind == KIND_FREE) begin
                        if (count_full) begin
                            rsp_next.status = STATUS_TABLE_FULL;
                        end else begin
                            wr_en         = 1'b1;
                            wr_addr       = count_reg[IDX_W-1:0];
                            wr_entry.addr = s_data.block_address;
                            wr_entry.size = s_data.block_size;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    rsp_next.address = rd_entry.addr;
                    if (ptr_at_last) begin
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        ptr_next = ptr_reg + IDX_W'(1);
                        rd_addr  = ptr_reg + IDX_W'(1);
                    end
                end else if (!ptr_at_zero) begin
                    ptr_next = ptr_reg - IDX_W'(1);
                    rd_addr  = ptr_reg - IDX_W'(1);
                end
            end
            ST_MOVE: begin
                // Close the gap: entry at ptr drops one place
                wr_en = 1'b1;
                if (ptr_at_last) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    rd_addr  = ptr_reg + IDX_W'(1);
                end
            end
            ST_CARVE: begin
                carve_commit = carve.fits;
                if (carve.fits) begin
                    rsp_next.address = carve.address;
                    rsp_next.status  = STATUS_OK;
                end else begin
                    rsp_next.address = '0;
                    rsp_next.status  = STATUS_NO_SPACE;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        rsp_reg <= rsp_next;
        if (s_fire) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= rsp_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FREE_ENTRIES))
        else $error("free table count past its depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH || state_reg == ST_MOVE) |-> (ptr_reg <= count_last))
        else $error("table pointer beyond the valid entries");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != STATUS_OK) |-> (m_data_reg.address == '0))
        else $error("failed request carries a non-zero address");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.kind == KIND_FREE && !count_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("free did not grow the table");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE) |-> (count_reg != '0))
        else $error("entry move with an empty table");

endmodule

@@ sv/ffa_table.sv @@
`timescale 1ns / 1ps
// Free table storage: one write port, one read port with registered data.
// Depends on ffa_pkg for the entry type.
module ffa_table #(
    parameter int DEPTH = ffa_pkg::FREE_ENTRIES_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ffa_pkg::entry_t      wr_entry,
    input  logic [IDX_W-1:0]     rd_addr,
    output ffa_pkg::entry_t      rd_entry
);
    import ffa_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

@@ sv/ffa_break.sv @@
`timescale 1ns / 1ps
// Break offset register and the carve check for allocations that miss the table.
// Depends on ffa_pkg for widths and the carve result type.
module ffa_break #(
    parameter int MIN_BLOCK_BYTES = ffa_pkg::MIN_BLOCK_BYTES_DEF,
    parameter int HEADER_BYTES    = ffa_pkg::HEADER_BYTES_DEF,
    parameter int SENTINEL_BYTES  = ffa_pkg::SENTINEL_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ffa_pkg::ADDR_W-1:0]    heap_base,
    input  logic [ffa_pkg::HEAP_W-1:0]    heap_bytes,
    input  logic [ffa_pkg::SIZE_W-1:0]    request_size,
    input  logic                          commit,
    output ffa_pkg::carve_t               carve
);
    import ffa_pkg::*;

    logic [BRK_W-1:0]  break_reg;
    logic [SIZE_W-1:0] payload;
    logic [SUM_W-1:0]  next_off;

    // Small requests still get a minimum payload
    assign payload  = (request_size < SIZE_W'(MIN_BLOCK_BYTES))
                      ? SIZE_W'(MIN_BLOCK_BYTES) : request_size;
    assign next_off = SUM_W'(break_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(payload);

    assign carve.fits    = (next_off <= SUM_W'(heap_bytes));
    assign carve.address = heap_base + ADDR_W'(break_reg) + ADDR_W'(HEADER_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            break_reg <= BRK_W'(SENTINEL_BYTES);
        end else if (commit) begin
            break_reg <= next_off[BRK_W-1:0];
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for first_fit_free_list_allocator: directed and random
// allocate/free traffic under random back-pressure, checked against a free-table model.
// Depends on ffa_pkg and the allocator RTL.
module testbench;
    import ffa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Mirrors the allocator: free table, break and heap window, plus the
    // replies still owed by the block.
    class heap_tracker;
        logic [ADDR_W-1:0] base;
        logic [HEAP_W-1:0] limit;
        logic [BRK_W-1:0]  brk;
        entry_t            free_list[$];
        rsp_t              awaited[$];
        int                mismatches;

        function new();
            base       = '0;
            limit      = HEAP_BYTES_RESET;
            brk        = BRK_W'(SENTINEL_BYTES_DEF);
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] value);
            if (idx == REG_HEAP_BASE) begin
                base = value;
            end else begin
                limit = value[HEAP_W-1:0];
            end
        endfunction

        function rsp_t note_request(req_t r);
            rsp_t             reply;
            entry_t           blk;
            logic [SUM_W-1:0] payload;
            logic [SUM_W-1:0] next_brk;
            bit               hit;
            reply.address = '0;
            reply.status  = STATUS_OK;
            hit = 1'b0;
            if (r.kind == KIND_FREE) begin
                if (free_list.size() >= FREE_ENTRIES_DEF) begin
                    reply.status = STATUS_TABLE_FULL;
                end else begin
                    blk.addr = r.block_address;
                    blk.size = r.block_size;
                    free_list.push_front(blk);
                end
            end else begin
                // zero-size requests skip the table altogether
                if (r.request_size != '0) begin
                    for (int i = 0; i < free_list.size() && !hit; i++) begin
                        if (free_list[i].size >= r.request_size) begin
                            reply.address = free_list[i].addr;
                            free_list.delete(i);
                            hit = 1'b1;
                        end
                    end
                end
                if (!hit) begin
                    payload = (r.request_size < MIN_BLOCK_BYTES_DEF) ?
                              SUM_W'(MIN_BLOCK_BYTES_DEF) : SUM_W'(r.request_size);
                    next_brk = SUM_W'(brk) + SUM_W'(HEADER_BYTES_DEF) + payload;
                    if (next_brk > SUM_W'(limit)) begin
                        reply.status = STATUS_NO_SPACE;
                    end else begin
                        reply.address = base + ADDR_W'(brk) + ADDR_W'(HEADER_BYTES_DEF);
                        brk = next_brk[BRK_W-1:0];
                    end
                end
            end
            awaited.push_back(reply);
            return reply;
        endfunction

        function void complain(string what, rsp_t want, rsp_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected address %h status %0d, got address %h status %0d",
                         $realtime, what, want.address, want.status, got.address, got.status);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0) begin
                want = '0;
                complain("unexpected result", want, got);
                return;
            end
            want = awaited.pop_front();
            if (got.address !== want.address)
                complain("address", want, got);
            if (got.status !== want.status)
                complain("status", want, got);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    req_t                 s_data;
    logic                 m_valid;
    logic                 m_ready;
    rsp_t                 m_data;

    heap_tracker tracker = new();
    entry_t      granted[$];
    int          gap_max;
    int          stall_max;
    int          hold_cycles;
    int          cycle_count;

    first_fit_free_list_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic req_t request(kind_t k, logic [SIZE_W-1:0] rsize,
                                     logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] bsize);
        req_t r;
        r.kind          = k;
        r.request_size  = rsize;
        r.block_address = addr;
        r.block_size    = bsize;
        return r;
    endfunction

    // Mostly small allocations and frees of blocks handed out earlier, so the
    // table sees real hits; the rest is zero-size requests, bogus frees and oversized requests.
    function automatic req_t random_request();
        req_t r;
        int   roll;
        int   pick;
        r.kind          = KIND_ALLOC;
        r.request_size  = SIZE_W'($urandom);
        r.block_address = $urandom;
        r.block_size    = SIZE_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                r.request_size = '0;
            end else if (roll < 70) begin
                r.request_size = SIZE_W'($urandom_range(1, 48));
            end else if (roll < 90) begin
                r.request_size = SIZE_W'($urandom_range(49, 512));
            end else if (roll < 97) begin
                r.request_size = SIZE_W'($urandom_range(513, 8192));
            end
        end else begin
            r.kind = KIND_FREE;
            if (granted.size() != 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, granted.size() - 1);
                r.block_address = granted[pick].addr;
                r.block_size    = granted[pick].size;
                granted.delete(pick);
            end
        end
        return r;
    endfunction

    // Hold valid across back-to-back transfers; drop it only for a gap.
    task automatic offer(req_t r);
        int     gap;
        rsp_t   predicted;
        entry_t blk;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        predicted = tracker.note_request(r);
        if (r.kind == KIND_ALLOC && predicted.status == STATUS_OK) begin
            blk.addr = predicted.address;
            blk.size = r.request_size;
            granted.push_back(blk);
            if (granted.size() > 64)
                void'(granted.pop_front());
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic write_heap(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] bytes);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HEAP_BASE;
        cfg_data  <= base;
        @(posedge aclk);
        tracker.write_reg(REG_HEAP_BASE, base);
        cfg_index <= REG_HEAP_BYTES;
        cfg_data  <= bytes;
        @(posedge aclk);
        tracker.write_reg(REG_HEAP_BYTES, bytes);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] bytes,
                             int items, int gap, int stall, int hold);
        drain();
        write_heap(base, bytes);
        gap_max     = gap;
        stall_max   = stall;
        hold_cycles = hold;
        repeat (items) offer(random_request());
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_result(m_data);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        entry_t blk;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_HEAP_BASE;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        gap_max     = 11;
        stall_max   = 11;
        hold_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, reset register values
        offer(request(KIND_ALLOC, '0, '0, '0));
        offer(request(KIND_ALLOC, 24'd1, '0, '0));
        offer(request(KIND_ALLOC, 24'd100, '0, '0));
        blk = granted[$];
        offer(request(KIND_FREE, '0, blk.addr, blk.size));
        offer(request(KIND_ALLOC, 24'd50, '0, '0));
        // the same all-ones block freed twice
        repeat (2) offer(request(KIND_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
        offer(request(KIND_ALLOC, '0, '0, '0));
        offer(request(KIND_FREE, '0, '0, '0));
        // skip the zero-size head entry and take an older one
        offer(request(KIND_ALLOC, 24'd1, '0, '0));
        offer(request(KIND_ALLOC, 24'hFF_FFFF, '0, '0));
        offer(request(KIND_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
        // fill the table, then one more to overflow it
        for (int i = 0; i < FREE_ENTRIES_DEF; i++)
            offer(request(KIND_FREE, '0, 32'h100 + 32'(i * 64), 24'(16 + i * 8)));

        run_phase($urandom, 32'd65536, 150, 11, 11, 300);
        run_phase(32'hFFFF_FFF8, 32'd16777216, 150, 0, 0, 0);
        run_phase(32'h0, 32'd0, 40, 11, 0, 0);
        run_phase(32'hFFFF_FFFF, ADDR_W'(tracker.brk) + 32'd300, 120, 0, 11, 0);
        run_phase($urandom, 32'd16777216, 160, 11, 11, 0);

        drain();
        repeat (60) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
